// ===== rtl/pesn_pkg.sv =====
// ----------------------------------------------------------------------------
// pesn_pkg : shared types and constants for the short name converter
// Character codes, datapath command and status bundles.
// ----------------------------------------------------------------------------
package pesn_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_Z    = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] SEP_RESET  = 8'h5C;

  // Source of an emitted byte
  typedef enum logic [1:0] {
    SRC_CHAR  = 2'd0,
    SRC_QMARK = 2'd1,
    SRC_SPACE = 2'd2,
    SRC_HELD  = 2'd3
  } out_src_t;

  // Position counter operation
  typedef enum logic [1:0] {
    POS_HOLD    = 2'd0,
    POS_ACC_INC = 2'd1,
    POS_PAD_INC = 2'd2,
    POS_SET_EXT = 2'd3
  } pos_op_t;

  typedef struct packed {
    logic     out_load;
    out_src_t out_src;
    logic     out_from_pad;
    logic     pad_load;
    logic     pad_q;
    logic     end_total;
    pos_op_t  pos_op;
  } cmd_t;

  typedef struct packed {
    logic plain;
    logic is_zero;
    logic is_star;
    logic is_dot;
    logic is_sep;
    logic name_fin;
    logic name_full;
    logic ext_fin;
    logic pad_fin;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/pesn_dpath.sv =====
// ----------------------------------------------------------------------------
// pesn_dpath : datapath of the short name converter
// Separator register, position counter, pad run registers, character
// classification and the output register.
// ----------------------------------------------------------------------------
module pesn_dpath #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN  = 3,
  parameter int POS_W    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  input  logic                 in_first,
  input  logic [7:0]           in_ch,
  input  pesn_pkg::cmd_t       cmd,
  output pesn_pkg::status_t    st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic [POS_W-1:0]     out_position,
  output logic                 out_last
);

  localparam int TOTAL = NAME_LEN + EXT_LEN;
  localparam logic [POS_W-1:0] POS_NAME      = POS_W'(NAME_LEN);
  localparam logic [POS_W-1:0] POS_NAME_LAST = POS_W'(NAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(TOTAL - 1);

  logic [7:0]       sep_r;
  logic [POS_W:0]   pos_r, pos_nxt;
  logic             pad_q_r, end_total_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r;
  logic [POS_W-1:0] out_pos_r;
  logic             out_last_r;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] base_in;
  logic [POS_W-1:0] emit_pos;
  logic [7:0]       emit_char;
  logic [7:0]       upper_ch;

  assign cfg_ready = 1'b1;
  assign pos_cur   = pos_r[POS_W-1:0];

  // Position of the request: a first flag restarts at zero
  assign base_in = in_first ? '0 : pos_cur;

  // Upper-case a-z only
  assign upper_ch = (in_ch >= pesn_pkg::CH_LC_A && in_ch <= pesn_pkg::CH_LC_Z) ?
                    in_ch - pesn_pkg::CASE_DELTA : in_ch;

  // Classify the character and report counter positions
  always_comb begin
    st.is_zero   = (in_ch == pesn_pkg::CH_NUL);
    st.is_star   = (in_ch == pesn_pkg::CH_STAR);
    st.is_dot    = (in_ch == pesn_pkg::CH_DOT);
    st.is_sep    = (in_ch == sep_r);
    st.plain     = !st.is_zero && !st.is_star && !st.is_sep && !st.is_dot &&
                   (in_ch != pesn_pkg::CH_SPACE);
    st.name_fin  = (base_in == POS_NAME_LAST);
    st.name_full = (base_in == POS_NAME);
    st.ext_fin   = (base_in == POS_LAST);
    st.pad_fin   = (pos_cur == (end_total_r ? POS_LAST : POS_NAME_LAST));
    st.out_free  = !out_valid_r || out_ready;
  end

  // Select the byte and position to emit
  assign emit_pos = cmd.out_from_pad ? pos_cur : base_in;

  always_comb begin
    case (cmd.out_src)
      pesn_pkg::SRC_CHAR:  emit_char = upper_ch;
      pesn_pkg::SRC_QMARK: emit_char = pesn_pkg::CH_QMARK;
      pesn_pkg::SRC_SPACE: emit_char = pesn_pkg::CH_SPACE;
      pesn_pkg::SRC_HELD:  emit_char = pad_q_r ? pesn_pkg::CH_QMARK : pesn_pkg::CH_SPACE;
      default:             emit_char = upper_ch;
    endcase
  end

  // Advance the position counter
  always_comb begin
    case (cmd.pos_op)
      pesn_pkg::POS_HOLD:    pos_nxt = pos_r;
      pesn_pkg::POS_ACC_INC: pos_nxt = {1'b0, base_in} + 1'b1;
      pesn_pkg::POS_PAD_INC: pos_nxt = pos_r + 1'b1;
      pesn_pkg::POS_SET_EXT: pos_nxt = {1'b0, POS_NAME};
      default:               pos_nxt = pos_r;
    endcase
  end

  // Output register: load on command, drop once taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= pesn_pkg::SEP_RESET;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        sep_r <= cfg_data;
      end
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold pad run settings and output payload
  always_ff @(posedge clk) begin
    if (cmd.pad_load) begin
      pad_q_r     <= cmd.pad_q;
      end_total_r <= cmd.end_total;
    end
    if (cmd.out_load) begin
      out_char_r <= emit_char;
      out_pos_r  <= emit_pos;
      out_last_r <= (emit_pos == POS_LAST);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= (POS_W+1)'(TOTAL))
    else $error("position counter past the end of the name");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("output register overwritten before it was taken");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && emit_pos == POS_LAST) |=> (out_valid_r && out_last_r))
    else $error("final byte not flagged");
`endif

endmodule

// ===== rtl/pesn_ctrl.sv =====
// ----------------------------------------------------------------------------
// pesn_ctrl : controller of the short name converter
// Tracks the name, skip, star, extension and done phases and sequences
// pad runs one byte per cycle while the output register is free.
// ----------------------------------------------------------------------------
module pesn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_first,
  output logic              in_ready,
  input  pesn_pkg::status_t st,
  output pesn_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_NAME = 3'd0;
  localparam logic [2:0] ST_SKIP = 3'd1;
  localparam logic [2:0] ST_STAR = 3'd2;
  localparam logic [2:0] ST_EXT  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;
  localparam logic [2:0] ST_PAD  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;
  logic [2:0] ph;
  logic       acc;
  logic       end_nm, ext_ch;
  logic       burst, b_q, b_total;
  logic [2:0] b_ret;

  assign in_ready = (state_r != ST_PAD) && st.out_free;
  assign acc      = in_valid && in_ready;
  assign ph       = in_first ? ST_NAME : state_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    end_nm    = 1'b0;
    ext_ch    = 1'b0;
    burst     = 1'b0;
    b_q       = 1'b0;
    b_total   = 1'b0;
    b_ret     = ST_DONE;

    // Decode the accepted request by phase
    if (acc) begin
      case (ph)
        ST_NAME: begin
          if (st.plain) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = pesn_pkg::SRC_CHAR;
            cmd.pos_op   = pesn_pkg::POS_ACC_INC;
            state_nxt    = st.name_fin ? ST_SKIP : ST_NAME;
          end else begin
            end_nm = 1'b1;
          end
        end
        ST_SKIP: begin
          if (st.is_zero || st.is_dot || st.is_sep) begin
            end_nm = 1'b1;
          end
        end
        ST_STAR: begin
          if (st.is_dot) begin
            state_nxt  = ST_EXT;
            cmd.pos_op = pesn_pkg::POS_SET_EXT;
          end else begin
            ext_ch = 1'b1;
          end
        end
        ST_EXT: begin
          ext_ch = 1'b1;
        end
        default: ;
      endcase
    end

    // Close the name part
    if (end_nm) begin
      if (st.is_star) begin
        if (st.name_full) begin
          state_nxt  = ST_STAR;
          cmd.pos_op = pesn_pkg::POS_SET_EXT;
        end else begin
          burst = 1'b1;
          b_q   = 1'b1;
          b_ret = ST_STAR;
        end
      end else if (st.is_dot) begin
        if (st.name_full) begin
          state_nxt  = ST_EXT;
          cmd.pos_op = pesn_pkg::POS_SET_EXT;
        end else begin
          burst = 1'b1;
          b_ret = ST_EXT;
        end
      end else begin
        burst   = 1'b1;
        b_total = 1'b1;
        b_ret   = ST_DONE;
      end
    end

    // Copy or close an extension character
    if (ext_ch) begin
      if (st.plain) begin
        cmd.out_load = 1'b1;
        cmd.out_src  = pesn_pkg::SRC_CHAR;
        cmd.pos_op   = pesn_pkg::POS_ACC_INC;
        state_nxt    = st.ext_fin ? ST_DONE : ST_EXT;
      end else begin
        burst   = 1'b1;
        b_q     = st.is_star;
        b_total = 1'b1;
        b_ret   = ST_DONE;
      end
    end

    // Start a pad run with its first byte
    if (burst) begin
      cmd.out_load  = 1'b1;
      cmd.out_src   = b_q ? pesn_pkg::SRC_QMARK : pesn_pkg::SRC_SPACE;
      cmd.pad_load  = 1'b1;
      cmd.pad_q     = b_q;
      cmd.end_total = b_total;
      cmd.pos_op    = pesn_pkg::POS_ACC_INC;
      ret_nxt       = b_ret;
      state_nxt     = (b_total ? st.ext_fin : st.name_fin) ? b_ret : ST_PAD;
    end

    // Continue a pad run while the output register frees
    if (state_r == ST_PAD && st.out_free) begin
      cmd.out_load     = 1'b1;
      cmd.out_src      = pesn_pkg::SRC_HELD;
      cmd.out_from_pad = 1'b1;
      cmd.pos_op       = pesn_pkg::POS_PAD_INC;
      if (st.pad_fin) begin
        state_nxt = ret_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NAME;
      ret_r   <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ret_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) |-> (ret_r == ST_STAR || ret_r == ST_EXT || ret_r == ST_DONE))
    else $error("pad run returns to an invalid phase");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_first && state_r == ST_DONE) |-> !cmd.out_load)
    else $error("byte emitted after the name was complete");

  a_pad_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD && state_nxt != ST_PAD) |-> (st.pad_fin && cmd.out_load))
    else $error("pad run left before its last byte");
`endif

endmodule

// ===== rtl/path_element_to_short_name.sv =====
// ----------------------------------------------------------------------------
// path_element_to_short_name : path element to 8.3 directory name converter
// Consumes one path character per request and produces the bytes of the
// upper-cased, padded directory style name.
// ----------------------------------------------------------------------------
// A request that copies a name or extension character, or that is skipped,
// never starts a pad run, so a path streams in at one character a cycle while
// the output side keeps up. A request that ends a part produces a pad run of
// up to NAME_LEN+EXT_LEN bytes; these leave the single output register one a
// cycle while the output side keeps up, and input is held off until the last
// one is loaded. Each byte appears on the output in the cycle after the
// request or pad step that loads it. After the final byte every request is
// dropped until one arrives with in_first set. The separator register resets
// to backslash and is written through the cfg_ channel, which is always ready.
module path_element_to_short_name #(
  parameter int NAME_LEN = 8,
  parameter int EXT_LEN  = 3,
  localparam int POS_W   = $clog2(NAME_LEN + EXT_LEN)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_first,
  input  logic [7:0]       in_ch,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_char,
  output logic [POS_W-1:0] out_position,
  output logic             out_last
);

  pesn_pkg::cmd_t    cmd;
  pesn_pkg::status_t st;

  // Phase control and pad sequencing
  pesn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_first (in_first),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Classification, counters and output register
  pesn_dpath #(
    .NAME_LEN (NAME_LEN),
    .EXT_LEN  (EXT_LEN),
    .POS_W    (POS_W)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_first     (in_first),
    .in_ch        (in_ch),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_position (out_position),
    .out_last     (out_last)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for path_element_to_short_name
// Streams path characters into the converter under random idling on both
// sides, predicts every 8.3 name byte in a scoreboard and compares each
// output byte with the oldest prediction. Covers several separator settings,
// including odd ones that clash with the delimiter characters.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_LEN = 8;
  localparam int EXT_LEN  = 3;
  localparam int SETTLE   = 16;
  localparam int TARGET   = 420;
  localparam int MAX_REPORTS = 30;

  typedef enum logic [2:0] {
    NAME_COPY  = 3'd0,
    NAME_SKIP  = 3'd1,
    AFTER_STAR = 3'd2,
    EXT_COPY   = 3'd3,
    NAME_DONE  = 3'd4
  } conv_phase_t;

  typedef struct {
    logic [7:0] chr;
    logic [3:0] pos;
    logic       last;
  } name_byte_t;

  // Predicts the name bytes from each accepted request and checks results
  class short_name_checker;
    logic [7:0]  sep;
    conv_phase_t phase;
    int unsigned part_count;
    name_byte_t  pending_bytes[$];
    int          errors;
    int          chars_taken;
    int          chars_acted;
    int          bytes_checked;

    function new();
      sep         = pesn_pkg::SEP_RESET;
      phase       = NAME_COPY;
      part_count  = 0;
      errors      = 0;
      chars_taken = 0;
      chars_acted = 0;
      bytes_checked = 0;
    endfunction

    function bit is_name_char(logic [7:0] c);
      return c != pesn_pkg::CH_NUL && c != pesn_pkg::CH_STAR && c != sep &&
             c != pesn_pkg::CH_DOT && c != pesn_pkg::CH_SPACE;
    endfunction

    function logic [7:0] to_upper(logic [7:0] c);
      return (c >= pesn_pkg::CH_LC_A && c <= pesn_pkg::CH_LC_Z) ?
             c - pesn_pkg::CASE_DELTA : c;
    endfunction

    function void push_byte(logic [7:0] c, int unsigned pos);
      name_byte_t nb;
      nb.chr  = c;
      nb.pos  = pos[3:0];
      nb.last = (pos == NAME_LEN + EXT_LEN - 1);
      pending_bytes.push_back(nb);
    endfunction

    function void pad_extension(logic [7:0] padc);
      for (int unsigned j = part_count; j < EXT_LEN; j++) push_byte(padc, NAME_LEN + j);
      phase      = NAME_DONE;
      part_count = 0;
    endfunction

    function void extension_char(logic [7:0] c);
      if (is_name_char(c)) begin
        push_byte(to_upper(c), NAME_LEN + part_count);
        part_count++;
        if (part_count >= EXT_LEN) begin
          phase      = NAME_DONE;
          part_count = 0;
        end
      end else begin
        pad_extension((c == pesn_pkg::CH_STAR) ? pesn_pkg::CH_QMARK : pesn_pkg::CH_SPACE);
      end
    endfunction

    function void close_name(logic [7:0] c);
      logic [7:0] padc;
      padc = (c == pesn_pkg::CH_STAR) ? pesn_pkg::CH_QMARK : pesn_pkg::CH_SPACE;
      for (int unsigned i = part_count; i < NAME_LEN; i++) push_byte(padc, i);
      part_count = 0;
      if (c == pesn_pkg::CH_STAR) phase = AFTER_STAR;
      else if (c == pesn_pkg::CH_DOT) phase = EXT_COPY;
      else pad_extension(pesn_pkg::CH_SPACE);
    endfunction

    // Advance the prediction by one accepted request
    function void take_char(logic first, logic [7:0] c);
      chars_taken++;
      if (first) begin
        phase      = NAME_COPY;
        part_count = 0;
      end
      if (phase != NAME_DONE) chars_acted++;
      case (phase)
        NAME_COPY: begin
          if (is_name_char(c)) begin
            push_byte(to_upper(c), part_count);
            part_count++;
            if (part_count >= NAME_LEN) phase = NAME_SKIP;
          end else begin
            close_name(c);
          end
        end
        NAME_SKIP: begin
          if (c == pesn_pkg::CH_NUL || c == pesn_pkg::CH_DOT || c == sep) close_name(c);
        end
        AFTER_STAR: begin
          phase      = EXT_COPY;
          part_count = 0;
          if (c != pesn_pkg::CH_DOT) extension_char(c);
        end
        EXT_COPY: extension_char(c);
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Compare one output byte with the oldest prediction
    function void check_byte(logic [7:0] c, logic [3:0] p, logic l);
      name_byte_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected byte, expected none, actual char %0h pos %0d last %0b",
                   $time, c, p, l);
        return;
      end
      want = pending_bytes.pop_front();
      if (c !== want.chr) flag("out_char", want.chr, c);
      if (p !== want.pos) flag("out_position", 8'(want.pos), 8'(p));
      if (l !== want.last) flag("out_last", 8'(want.last), 8'(l));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_first = 1'b0;
  logic [7:0] in_ch = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic [3:0] out_position;
  logic       out_last;

  short_name_checker sb = new();
  bit idle_on = 1'b1;
  int out_hold = 0;
  int sep_settings = 1;

  path_element_to_short_name u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_first     (in_first),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_position (out_position),
    .out_last     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side at random after each byte it takes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) out_hold = idle_on ? $urandom_range(0, 4) : 0;
      else if (out_hold > 0) out_hold--;
      out_ready <= (out_hold == 0);
    end
  end

  // Watch all three handshakes at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.sep = cfg_data;
      if (in_valid && in_ready) sb.take_char(in_first, in_ch);
      if (out_valid && out_ready) sb.check_byte(out_char, out_position, out_last);
    end
  end

  task automatic send_char(input logic first, input logic [7:0] c);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first <= first;
    in_ch    <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the input until every predicted byte has left the block
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    sep_settings++;
  endtask

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do begin
      case ($urandom_range(0, 3))
        0, 1: c = 8'($urandom_range(pesn_pkg::CH_LC_A, pesn_pkg::CH_LC_Z));
        2:    c = ($urandom_range(0, 1) != 0) ? 8'($urandom_range("A", "Z"))
                                              : 8'($urandom_range("0", "9"));
        default: c = 8'($urandom_range(0, 255));
      endcase
    end while (!sb.is_name_char(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_stop_char();
    case ($urandom_range(0, 5))
      0: return pesn_pkg::CH_NUL;
      1: return sb.sep;
      2: return pesn_pkg::CH_SPACE;
      3: return pesn_pkg::CH_STAR;
      4: return pesn_pkg::CH_DOT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One path element: mostly well formed, sometimes plain noise
  task automatic send_element();
    int  name_len;
    int  ext_len;
    int  tail;
    bit  fresh;
    fresh   = 1'b1;
    idle_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 4) == 0) begin
      tail = $urandom_range(1, 10);
      for (int k = 0; k < tail; k++)
        send_char((k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0),
                  8'($urandom_range(0, 255)));
      return;
    end
    name_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 8);
    for (int k = 0; k < name_len; k++) begin
      send_char(fresh, pick_name_char());
      fresh = 1'b0;
    end
    case ($urandom_range(0, 3))
      0: begin
        send_char(fresh, pesn_pkg::CH_DOT);
        fresh = 1'b0;
      end
      1: begin
        send_char(fresh, pesn_pkg::CH_STAR);
        send_char(1'b0, pesn_pkg::CH_DOT);
        fresh = 1'b0;
      end
      2: begin
        send_char(fresh, pesn_pkg::CH_STAR);
        fresh = 1'b0;
      end
      default: begin
        send_char(fresh, pick_stop_char());
        fresh = 1'b0;
      end
    endcase
    ext_len = $urandom_range(0, 4);
    for (int k = 0; k < ext_len; k++) send_char(1'b0, pick_name_char());
    if (ext_len < EXT_LEN) send_char(1'b0, pick_stop_char());
    tail = $urandom_range(0, 2);
    for (int k = 0; k < tail; k++) send_char(1'b0, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0] seps[8];
    int         step_goal;
    seps = '{pesn_pkg::CH_NUL, 8'hFF, pesn_pkg::CH_STAR, pesn_pkg::CH_DOT,
             pesn_pkg::CH_SPACE, "/", "a", pesn_pkg::SEP_RESET};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Case edges, then '*' with the '.' after it consumed and a short extension
    send_char(1'b1, "a");
    send_char(1'b0, "z");
    send_char(1'b0, 8'h60);
    send_char(1'b0, 8'h7B);
    send_char(1'b0, pesn_pkg::CH_STAR);
    send_char(1'b0, pesn_pkg::CH_DOT);
    send_char(1'b0, "q");
    send_char(1'b0, pesn_pkg::CH_SPACE);
    // Overlong name ended by the separator from the skipping phase
    send_char(1'b1, "B");
    send_char(1'b0, "0");
    send_char(1'b0, "9");
    send_char(1'b0, 8'hFF);
    send_char(1'b0, 8'h80);
    send_char(1'b0, "x");
    send_char(1'b0, "y");
    send_char(1'b0, "Z");
    send_char(1'b0, "w");
    send_char(1'b0, pesn_pkg::SEP_RESET);
    // Empty element, then a character the finished name drops
    send_char(1'b1, pesn_pkg::CH_NUL);
    send_char(1'b0, 8'hFF);
    // Restart mid-name, dot at the very start, star in the extension
    send_char(1'b1, "m");
    send_char(1'b1, pesn_pkg::CH_DOT);
    send_char(1'b0, pesn_pkg::CH_STAR);
    drain();

    // Random elements under each separator setting, the reset one first
    for (int p = 0; p <= 8; p++) begin
      if (p > 0) write_separator(seps[p-1]);
      step_goal = sb.chars_taken + TARGET / 9;
      while (sb.chars_taken < step_goal) begin
        send_element();
        if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
    end

    $display("Sent %0d characters (%0d acted on) under %0d separator settings",
             sb.chars_taken, sb.chars_acted, sep_settings);
    $display("Checked %0d name bytes, %0d errors", sb.bytes_checked, sb.errors);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Timeout with %0d name bytes outstanding", sb.pending_bytes.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pesn_pkg.sv
rtl/pesn_dpath.sv
rtl/pesn_ctrl.sv
rtl/path_element_to_short_name.sv
tb/testbench.sv
